// File: rtl/mdcl_pkg.sv
//------------------------------------------------------------------------------
// mdcl_pkg
// Types, codes and helpers shared by the multidrop command link master.
//------------------------------------------------------------------------------
`default_nettype none

package mdcl_pkg;

  localparam int PAYLOAD_DEPTH_DEF = 32;

  localparam logic [7:0] TIMEOUT_RESET = 8'd30;
  localparam logic [3:0] RETRY_RESET   = 4'd3;

  // Address word marker and checksum mask.
  localparam logic [8:0] ADDR_MARK = 9'h100;
  localparam logic [7:0] CKS_MASK  = 8'h7F;

  // Answer delimiters.
  localparam logic [7:0] DELIM_LF    = 8'h0A;
  localparam logic [7:0] DELIM_CR    = 8'h0D;
  localparam logic [7:0] DELIM_SEMI  = 8'h3B;
  localparam logic [7:0] DELIM_BANG  = 8'h21;
  localparam logic [7:0] DELIM_QUERY = 8'h3F;
  localparam logic [7:0] DELIM_DOLL  = 8'h24;

  // Configuration register indexes.
  localparam logic REG_TIMEOUT = 1'b0;
  localparam logic REG_RETRY   = 1'b1;

  typedef enum logic [2:0] {
    CMD_START   = 3'd0,
    CMD_PAYLOAD = 3'd1,
    CMD_SEND    = 3'd2,
    CMD_LINE    = 3'd3,
    CMD_TICK    = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_ACKED    = 3'd1,
    EV_ACK_FAIL = 3'd2,
    EV_ANS_DONE = 3'd3,
    EV_ANS_TMO  = 3'd4,
    EV_IDLE     = 3'd5
  } ev_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_LOAD,
    PH_ACK,
    PH_ANS,
    PH_CKS
  } phase_t;

  typedef enum logic [2:0] {
    SQ_IDLE,
    SQ_ADDR,
    SQ_RD,
    SQ_DATA,
    SQ_CKS,
    SQ_ONE
  } seq_t;

  function automatic logic is_delim(input logic [7:0] b);
    return (b == DELIM_LF) || (b == DELIM_CR) || (b == DELIM_SEMI) ||
           (b == DELIM_BANG) || (b == DELIM_QUERY) || (b == DELIM_DOLL);
  endfunction

endpackage

`default_nettype wire

// File: rtl/multidrop_command_link_master.sv
//------------------------------------------------------------------------------
// multidrop_command_link_master
// Master side of a 9-bit multidrop serial command link with retries and
// answer collection.
//------------------------------------------------------------------------------
// Usage: every input word on the s_ channel is one command: start (address and
// answer flag), payload byte, send, a byte received from the line, or a
// millisecond tick; the command code rides on s_tuser. Result words leave on
// the m_ channel: line words to transmit, answer characters and events, with
// m_tlast marking the final word that one input word caused. Inputs that do
// nothing produce no output word.
// Sequencing: an input word with no result is taken without leaving idle; one
// with a single result passes through the single-result state. A frame send or
// retransmit passes through an address state, a read and a data state for each
// payload byte (it is fetched through the registered read port of the payload
// RAM), then a checksum state. s_tready is low while a word is being worked on,
// and m_tready holding the output register full stalls the frame. A finished
// word may wait in the output register while the next input word is accepted.
// Reset (rst, synchronous) returns to idle with timeout_ticks = 30 and
// retry_limit = 3. Configuration is written through cfg_we/cfg_index/cfg_wdata,
// by the user only while the block is idle; the block does not enforce this. The
// payload RAM is not cleared; only bytes loaded since the last start command are sent.
//------------------------------------------------------------------------------
`default_nettype none

module multidrop_command_link_master
  import mdcl_pkg::*;
#(
  parameter int PAYLOAD_DEPTH = PAYLOAD_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Input command words.
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // unit_addr[7:0], data_byte[15:8], want_answer[16]
  input  wire logic [2:0]  s_tuser,   // cmd[2:0]
  // Result words.
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,   // tx_word[8:0], answer_byte[16:9]
  output logic [4:0]       m_tuser,   // tx_valid[0], answer_valid[1], event_res[4:2]
  output logic             m_tlast,
  // Configuration writes.
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [7:0]  cfg_wdata
);

  localparam int AW = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;
  localparam int CW = $clog2(PAYLOAD_DEPTH + 1);

  // Configuration registers.
  logic [7:0] timeout_ticks;
  logic [3:0] retry_limit;

  // Command state.
  phase_t      phase;
  logic [CW-1:0] payload_count;
  logic [7:0]  payload_sum;
  logic [7:0]  target_addr;
  logic        answer_wanted;
  logic [7:0]  tick_count;
  logic [3:0]  retries_left;

  // Output sequencer.
  seq_t          seq, seq_next;
  logic [CW-1:0] idx;
  ev_t           pend_ev;
  logic          pend_av;
  logic [7:0]    pend_ab;

  // Output register.
  logic       out_txv;
  logic [8:0] out_word;
  logic       out_av;
  logic [7:0] out_ab;
  ev_t        out_ev;
  logic       out_last;

  // Input word fields.
  cmd_t       in_cmd;
  logic [7:0] in_addr;
  logic [7:0] in_byte;
  logic       in_want;

  assign in_cmd  = cmd_t'(s_tuser);
  assign in_addr = s_tdata[7:0];
  assign in_byte = s_tdata[15:8];
  assign in_want = s_tdata[16];

  logic accept;
  logic slot_free;
  assign s_tready  = (seq == SQ_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign slot_free = !m_tvalid || m_tready;

  // Tick timeout compare, shared by all three waiting phases.
  logic [8:0] tick_inc;
  logic       tick_expired;
  assign tick_inc     = {1'b0, tick_count} + 9'd1;
  assign tick_expired = (tick_inc >= {1'b0, timeout_ticks});

  logic load_ok;
  assign load_ok = (phase == PH_LOAD) && (payload_count < CW'(PAYLOAD_DEPTH));

  // Decode of the word at the input: which kind of output it causes.
  logic do_frame;
  logic do_one;
  ev_t  one_ev;
  logic one_av;

  always_comb begin
    do_frame = 1'b0;
    do_one   = 1'b0;
    one_ev   = EV_NONE;
    one_av   = 1'b0;
    case (in_cmd)
      CMD_SEND: begin
        do_frame = (phase == PH_LOAD);
      end
      CMD_LINE: begin
        if (phase == PH_ACK) begin
          do_one = 1'b1;
          one_ev = EV_ACKED;
        end else if (phase == PH_ANS) begin
          do_one = 1'b1;
          if (is_delim(in_byte)) begin
            one_ev = EV_ANS_DONE;
          end else begin
            one_av = 1'b1;
          end
        end else if (phase == PH_CKS) begin
          do_one = 1'b1;
          one_ev = EV_IDLE;
        end
      end
      CMD_TICK: begin
        if (tick_expired) begin
          if (phase == PH_ACK) begin
            if (retries_left != 4'd0) begin
              do_frame = 1'b1;
            end else begin
              do_one = 1'b1;
              one_ev = EV_ACK_FAIL;
            end
          end else if (phase == PH_ANS) begin
            do_one = 1'b1;
            one_ev = EV_ANS_TMO;
          end else if (phase == PH_CKS) begin
            do_one = 1'b1;
            one_ev = EV_IDLE;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Payload store.
  logic       ram_we;
  logic [7:0] ram_rdata;
  assign ram_we = accept && (in_cmd == CMD_PAYLOAD) && load_ok;

  mdcl_ram #(
    .WIDTH (8),
    .DEPTH (PAYLOAD_DEPTH)
  ) u_payload (
    .clk   (clk),
    .we    (ram_we),
    .waddr (payload_count[AW-1:0]),
    .wdata (in_byte),
    .raddr (idx[AW-1:0]),
    .rdata (ram_rdata)
  );

  // Configuration.
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TIMEOUT_RESET;
      retry_limit   <= RETRY_RESET;
    end else if (cfg_we) begin
      if (cfg_index == REG_TIMEOUT) begin
        timeout_ticks <= cfg_wdata;
      end else begin
        retry_limit <= cfg_wdata[3:0];
      end
    end
  end

  // Command state update, done in the cycle the word is accepted.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      payload_count <= '0;
      payload_sum   <= '0;
      target_addr   <= '0;
      answer_wanted <= 1'b0;
      tick_count    <= '0;
      retries_left  <= '0;
    end else if (accept) begin
      case (in_cmd)
        CMD_START: begin
          target_addr   <= in_addr;
          answer_wanted <= in_want;
          payload_count <= '0;
          payload_sum   <= '0;
          tick_count    <= '0;
          retries_left  <= '0;
          phase         <= PH_LOAD;
        end
        CMD_PAYLOAD: begin
          if (load_ok) begin
            payload_count <= payload_count + CW'(1);
            payload_sum   <= payload_sum + in_byte;
          end
        end
        CMD_SEND: begin
          if (phase == PH_LOAD) begin
            tick_count   <= '0;
            retries_left <= retry_limit;
            phase        <= PH_ACK;
          end
        end
        CMD_LINE: begin
          if (phase == PH_ACK) begin
            tick_count <= '0;
            phase      <= answer_wanted ? PH_ANS : PH_IDLE;
          end else if (phase == PH_ANS) begin
            tick_count <= '0;
            if (is_delim(in_byte)) begin
              phase <= PH_CKS;
            end
          end else if (phase == PH_CKS) begin
            tick_count <= '0;
            phase      <= PH_IDLE;
          end
        end
        CMD_TICK: begin
          if (phase == PH_ACK || phase == PH_ANS || phase == PH_CKS) begin
            if (!tick_expired) begin
              tick_count <= tick_inc[7:0];
            end else begin
              tick_count <= '0;
              if (phase == PH_ACK) begin
                if (retries_left != 4'd0) begin
                  retries_left <= retries_left - 4'd1;
                end else begin
                  phase <= answer_wanted ? PH_ANS : PH_IDLE;
                end
              end else begin
                phase <= PH_IDLE;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Sequencer next state.
  always_comb begin
    seq_next = seq;
    unique case (seq)
      SQ_IDLE: begin
        if (accept && do_frame) begin
          seq_next = SQ_ADDR;
        end else if (accept && do_one) begin
          seq_next = SQ_ONE;
        end
      end
      SQ_ADDR: begin
        if (slot_free) begin
          seq_next = (payload_count == '0) ? SQ_CKS : SQ_RD;
        end
      end
      SQ_RD: begin
        seq_next = SQ_DATA;
      end
      SQ_DATA: begin
        if (slot_free) begin
          seq_next = ((idx + CW'(1)) == payload_count) ? SQ_CKS : SQ_RD;
        end
      end
      SQ_CKS: begin
        if (slot_free) begin
          seq_next = SQ_IDLE;
        end
      end
      SQ_ONE: begin
        if (slot_free) begin
          seq_next = SQ_IDLE;
        end
      end
      default: begin
        seq_next = SQ_IDLE;
      end
    endcase
  end

  // Sequencer outputs: the word pushed into the output register.
  logic       push;
  logic       push_txv;
  logic [8:0] push_word;
  logic       push_av;
  logic [7:0] push_ab;
  ev_t        push_ev;
  logic       push_last;

  always_comb begin
    push      = 1'b0;
    push_txv  = 1'b0;
    push_word = '0;
    push_av   = 1'b0;
    push_ab   = '0;
    push_ev   = EV_NONE;
    push_last = 1'b0;
    unique case (seq)
      SQ_ADDR: begin
        push      = slot_free;
        push_txv  = 1'b1;
        push_word = ADDR_MARK | {1'b0, target_addr};
      end
      SQ_DATA: begin
        push      = slot_free;
        push_txv  = 1'b1;
        push_word = {1'b0, ram_rdata};
      end
      SQ_CKS: begin
        push      = slot_free;
        push_txv  = 1'b1;
        push_word = {1'b0, payload_sum & CKS_MASK};
        push_last = 1'b1;
      end
      SQ_ONE: begin
        push      = slot_free;
        push_av   = pend_av;
        push_ab   = pend_ab;
        push_ev   = pend_ev;
        push_last = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq <= SQ_IDLE;
      idx <= '0;
    end else begin
      seq <= seq_next;
      if (seq == SQ_ADDR) begin
        idx <= '0;
      end else if (seq == SQ_DATA && slot_free) begin
        idx <= idx + CW'(1);
      end
    end
  end

  // Pending single result, captured with the input word.
  always_ff @(posedge clk) begin
    if (accept) begin
      pend_ev <= one_ev;
      pend_av <= one_av;
      pend_ab <= one_av ? in_byte : 8'd0;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (push) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_txv  <= push_txv;
      out_word <= push_word;
      out_av   <= push_av;
      out_ab   <= push_ab;
      out_ev   <= push_ev;
      out_last <= push_last;
    end
  end

  assign m_tdata = {7'd0, out_ab, out_word};
  assign m_tuser = {out_ev, out_av, out_txv};
  assign m_tlast = out_last;

  // The fill count never passes the store depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    payload_count <= CW'(PAYLOAD_DEPTH))
    else $error("payload count beyond store depth");

  // Payload fetches stay inside the loaded bytes.
  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    (seq == SQ_RD || seq == SQ_DATA) |-> (idx < payload_count))
    else $error("payload fetch beyond loaded bytes");

  // The final word of an input is never an address word.
  a_last_not_addr: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> !m_tdata[8])
    else $error("address word marked as last");

  // Line words carry no event and no answer character.
  a_tx_clean: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> (m_tuser[4:1] == 4'd0))
    else $error("line word carries event or answer");

endmodule

`default_nettype wire

// File: rtl/mdcl_ram.sv
//------------------------------------------------------------------------------
// mdcl_ram
// Generic single write port, single read port RAM with registered read data.
//------------------------------------------------------------------------------
`default_nettype none

module mdcl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: bench/multidrop_command_link_master_tb.sv
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// multidrop_command_link_master_tb
// Self-checking bench for the multidrop command link master.
//------------------------------------------------------------------------------
// A directed table walks the commands out of place, the frame layout, the
// acknowledge, answer, delimiter and checksum paths, retries and timeouts.
// Random commands follow, mostly complete exchanges with random content, plus
// noise and broken exchanges. Every accepted word runs through a behavioral
// model of the link master kept here. Each result word is compared field by
// field with the oldest predicted word.
//------------------------------------------------------------------------------

module multidrop_command_link_master_tb;
  import mdcl_pkg::*;

  localparam int PAY_DEPTH       = PAYLOAD_DEPTH_DEF;
  // A frame replay is the slowest piece of work: a read and a data step per payload byte.
  localparam int DRAIN_CYCLES    = 2 * PAY_DEPTH + 16;
  localparam int HOLD_CYCLES     = 400;
  // Least number of input words per random phase, ticks included.
  localparam int ITEMS_PER_PHASE = 14;
  localparam int N_PHASES        = 5;
  localparam int LIMIT_NS        = 4_000_000;

  // Highest code the cmd field can carry. Codes above CMD_TICK do nothing.
  localparam logic [2:0] CMD_UNUSED_TOP = 3'h7;

  // One result word as the block should present it.
  typedef struct packed {
    logic       tx_valid;
    logic [8:0] tx_word;
    logic       answer_valid;
    logic [7:0] answer_byte;
    ev_t        ev;
    logic       last;
  } link_word_t;

  localparam link_word_t NO_RES = '0;

  // A row of the directed table. For a word row, arg_a is unit_addr and arg_b
  // is data_byte. For a config row, arg_a is timeout_ticks, arg_b retry_limit.
  typedef enum {ROW_WORD, ROW_CFG} row_kind_t;
  typedef struct {
    row_kind_t  kind;
    logic [2:0] cmd;
    logic [7:0] arg_a;
    logic [7:0] arg_b;
    logic       want;
    bit         typed;
    link_word_t res;
  } dir_row_t;

  logic        clk;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata   = '0;   // unit_addr[7:0], data_byte[15:8], want_answer[16]
  logic [2:0]  s_tuser   = '0;   // cmd[2:0]
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [23:0] m_tdata;          // tx_word[8:0], answer_byte[16:9]
  logic [4:0]  m_tuser;          // tx_valid[0], answer_valid[1], event_res[4:2]
  logic        m_tlast;
  logic        cfg_we    = 1'b0;
  logic        cfg_index = 1'b0;
  logic [7:0]  cfg_wdata = '0;

  multidrop_command_link_master #(.PAYLOAD_DEPTH(PAY_DEPTH)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // The run is cut off here if the block ever stops answering.
  initial begin
    #LIMIT_NS;
    $display("status: fail");
    $finish;
  end

  //----------------------------------------------------------------------------
  // Link model state, as after reset.
  //----------------------------------------------------------------------------
  int         cfg_timeout  = int'(TIMEOUT_RESET);
  int         cfg_retry    = int'(RETRY_RESET);
  phase_t     lk_phase     = PH_IDLE;
  logic [7:0] pay_mem [PAY_DEPTH];
  int         pay_cnt      = 0;
  logic [7:0] pay_sum      = '0;
  logic [7:0] tgt_addr     = '0;
  logic       ans_wanted   = 1'b0;
  int         tick_cnt     = 0;
  int         retries_left = 0;

  // Words predicted for the input word just accepted, and the words that are
  // still owed by the block, oldest first.
  link_word_t step_out [$];
  link_word_t link_expect [$];

  int  last_step_n   = 0;
  int  words_sent    = 0;
  int  ticks_sent    = 0;
  int  words_checked = 0;
  int  frames_sent   = 0;
  int  settings_done = 0;
  int  hold_cycles   = 0;
  int  mismatches    = 0;
  int  hold_asks     = 0;
  bit  steady        = 1'b0;

  dir_row_t dir_rows [$];

  function automatic void emit_word(input logic txv, input logic [8:0] txw, input logic av,
                                    input logic [7:0] ab, input ev_t ev);
    link_word_t w;
    w.tx_valid     = txv;
    w.tx_word      = txw;
    w.answer_valid = av;
    w.answer_byte  = ab;
    w.ev           = ev;
    w.last         = 1'b0;
    step_out.push_back(w);
  endfunction

  // Address word, every stored payload byte, then the 7-bit checksum word.
  function automatic void replay_frame();
    emit_word(1'b1, ADDR_MARK | {1'b0, tgt_addr}, 1'b0, 8'h00, EV_NONE);
    for (int i = 0; i < pay_cnt; i++)
      emit_word(1'b1, {1'b0, pay_mem[i]}, 1'b0, 8'h00, EV_NONE);
    emit_word(1'b1, {1'b0, pay_sum & CKS_MASK}, 1'b0, 8'h00, EV_NONE);
    frames_sent++;
  endfunction

  // A failed acknowledge carries on exactly like a good one.
  function automatic void finish_ack();
    tick_cnt = 0;
    lk_phase = ans_wanted ? PH_ANS : PH_IDLE;
  endfunction

  function automatic bit ends_answer(input logic [7:0] b);
    return b == DELIM_LF || b == DELIM_CR || b == DELIM_SEMI ||
           b == DELIM_BANG || b == DELIM_QUERY || b == DELIM_DOLL;
  endfunction

  function automatic int eff_timeout();
    return (cfg_timeout == 0) ? 1 : cfg_timeout;
  endfunction

  // Advances the link model by one command word and fills step_out.
  function automatic void predict_word(input logic [2:0] cmd, input logic [7:0] addr,
                                       input logic [7:0] dbyte, input logic want);
    case (cmd)
      CMD_START: begin
        // A start aborts whatever was going on.
        tgt_addr     = addr;
        ans_wanted   = want;
        pay_cnt      = 0;
        pay_sum      = '0;
        tick_cnt     = 0;
        retries_left = 0;
        lk_phase     = PH_LOAD;
      end
      CMD_PAYLOAD: begin
        // Bytes past the end of the store are dropped.
        if (lk_phase == PH_LOAD && pay_cnt < PAY_DEPTH) begin
          pay_mem[pay_cnt] = dbyte;
          pay_cnt++;
          pay_sum = pay_sum + dbyte;
        end
      end
      CMD_SEND: begin
        if (lk_phase == PH_LOAD) begin
          replay_frame();
          tick_cnt     = 0;
          retries_left = cfg_retry;
          lk_phase     = PH_ACK;
        end
      end
      CMD_LINE: begin
        if (lk_phase == PH_ACK) begin
          emit_word(1'b0, 9'h000, 1'b0, 8'h00, EV_ACKED);
          finish_ack();
        end else if (lk_phase == PH_ANS) begin
          tick_cnt = 0;
          if (ends_answer(dbyte)) begin
            emit_word(1'b0, 9'h000, 1'b0, 8'h00, EV_ANS_DONE);
            lk_phase = PH_CKS;
          end else begin
            emit_word(1'b0, 9'h000, 1'b1, dbyte, EV_NONE);
          end
        end else if (lk_phase == PH_CKS) begin
          emit_word(1'b0, 9'h000, 1'b0, 8'h00, EV_IDLE);
          tick_cnt = 0;
          lk_phase = PH_IDLE;
        end
      end
      CMD_TICK: begin
        if (lk_phase == PH_ACK || lk_phase == PH_ANS || lk_phase == PH_CKS) begin
          if (tick_cnt + 1 < cfg_timeout) begin
            tick_cnt++;
          end else begin
            tick_cnt = 0;
            case (lk_phase)
              PH_ACK: begin
                if (retries_left > 0) begin
                  retries_left--;
                  replay_frame();
                end else begin
                  emit_word(1'b0, 9'h000, 1'b0, 8'h00, EV_ACK_FAIL);
                  finish_ack();
                end
              end
              PH_ANS: begin
                emit_word(1'b0, 9'h000, 1'b0, 8'h00, EV_ANS_TMO);
                lk_phase = PH_IDLE;
              end
              default: begin
                emit_word(1'b0, 9'h000, 1'b0, 8'h00, EV_IDLE);
                lk_phase = PH_IDLE;
              end
            endcase
          end
        end
      end
      default: ;
    endcase
  endfunction

  //----------------------------------------------------------------------------
  // Checking.
  //----------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] wanted);
    if (mismatches < 30)
      $display("mismatch at %0t ns, result word %0d: %s got %0h wanted %0h",
               $time, words_checked, what, got, wanted);
    mismatches++;
  endtask

  // Outputs are sampled at the edge, before the block updates them.
  always @(posedge clk) begin
    link_word_t w;
    if (!rst && m_tvalid && m_tready) begin
      if (link_expect.size() == 0) begin
        report_mismatch("word with nothing pending", 32'({m_tuser, m_tdata[16:0]}), 32'd0);
      end else begin
        w = link_expect.pop_front();
        if (m_tuser[0] !== w.tx_valid)
          report_mismatch("tx_valid", 32'(m_tuser[0]), 32'(w.tx_valid));
        if (m_tdata[8:0] !== w.tx_word)
          report_mismatch("tx_word", 32'(m_tdata[8:0]), 32'(w.tx_word));
        if (m_tuser[1] !== w.answer_valid)
          report_mismatch("answer_valid", 32'(m_tuser[1]), 32'(w.answer_valid));
        if (m_tdata[16:9] !== w.answer_byte)
          report_mismatch("answer_byte", 32'(m_tdata[16:9]), 32'(w.answer_byte));
        if (m_tuser[4:2] !== w.ev)
          report_mismatch("event_res", 32'(m_tuser[4:2]), 32'(w.ev));
        if (m_tlast !== w.last)
          report_mismatch("last", 32'(m_tlast), 32'(w.last));
      end
      words_checked++;
    end
  end

  //----------------------------------------------------------------------------
  // Receiver. It idles at random, except in steady stretches, and on request
  // holds m_tready low for HOLD_CYCLES so that the block backs up.
  //----------------------------------------------------------------------------
  int hold_left = 0;
  int hold_seen = 0;

  always @(posedge clk) begin
    if (hold_asks != hold_seen) begin
      hold_seen = hold_asks;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      hold_cycles++;
      m_tready <= 1'b0;
    end else begin
      m_tready <= steady || ($urandom_range(0, 99) >= 20);
    end
  end

  //----------------------------------------------------------------------------
  // Sender.
  //----------------------------------------------------------------------------
  function automatic logic [7:0] rnd8();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic rnd1();
    return 1'($urandom_range(0, 1));
  endfunction

  function automatic logic [7:0] pick_delim();
    case ($urandom_range(0, 5))
      0:       return DELIM_LF;
      1:       return DELIM_CR;
      2:       return DELIM_SEMI;
      3:       return DELIM_BANG;
      4:       return DELIM_QUERY;
      default: return DELIM_DOLL;
    endcase
  endfunction

  // Offers one command word, maybe after a short gap, and waits for the
  // handshake. s_tvalid is left high so that a following word goes out
  // back to back. Once accepted, the word is run through the link model; a
  // typed row replaces the model's output by the single result it gives.
  task automatic send_word(input logic [2:0] cmd, input logic [7:0] addr, input logic [7:0] dbyte,
                           input logic want, input bit typed, input link_word_t typed_res);
    link_word_t w;
    if (!steady && $urandom_range(0, 99) < 20) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {7'd0, want, dbyte, addr};
    do @(posedge clk); while (!s_tready);
    step_out.delete();
    predict_word(cmd, addr, dbyte, want);
    if (step_out.size() != 0) begin
      w = step_out.pop_back();
      w.last = 1'b1;
      step_out.push_back(w);
    end
    if (typed) begin
      step_out.delete();
      step_out.push_back(typed_res);
    end
    last_step_n = step_out.size();
    foreach (step_out[i]) link_expect.push_back(step_out[i]);
    if (cmd == CMD_TICK) ticks_sent++;
    else words_sent++;
  endtask

  // Ticks that stay short of the timeout of the byte being awaited.
  task automatic tick_some(input int most);
    int room;
    room = eff_timeout() - 1 - tick_cnt;
    repeat ($urandom_range(0, (room < most) ? room : most))
      send_word(CMD_TICK, rnd8(), rnd8(), rnd1(), 1'b0, NO_RES);
  endtask

  // Ticks until the awaited byte times out.
  task automatic tick_out();
    do send_word(CMD_TICK, rnd8(), rnd8(), rnd1(), 1'b0, NO_RES);
    while (last_step_n == 0);
  endtask

  // One exchange: start, payload, send, acknowledge or retries, then the
  // answer and its checksum byte if one was asked for. Some exchanges are
  // cut short so that the next start lands in the middle of one.
  task automatic run_command(input bit big);
    int n;
    int r;
    send_word(CMD_START, rnd8(), rnd8(), rnd1(), 1'b0, NO_RES);
    if (big) n = PAY_DEPTH;
    else if ($urandom_range(0, 9) == 0) n = $urandom_range(PAY_DEPTH - 4, PAY_DEPTH + 2);
    else n = $urandom_range(0, 6);
    repeat (n) send_word(CMD_PAYLOAD, rnd8(), rnd8(), rnd1(), 1'b0, NO_RES);
    if (!big && $urandom_range(0, 99) < 6) return;
    send_word(CMD_SEND, rnd8(), rnd8(), rnd1(), 1'b0, NO_RES);
    while (lk_phase == PH_ACK) begin
      if (!big && $urandom_range(0, 99) < 4) return;
      if ($urandom_range(0, 99) < 65) begin
        tick_some(12);
        send_word(CMD_LINE, rnd8(), rnd8(), rnd1(), 1'b0, NO_RES);
      end else begin
        tick_out();
      end
    end
    while (lk_phase == PH_ANS) begin
      r = $urandom_range(0, 99);
      tick_some(8);
      if (r < 70) send_word(CMD_LINE, rnd8(), rnd8(), rnd1(), 1'b0, NO_RES);
      else if (r < 88) send_word(CMD_LINE, rnd8(), pick_delim(), rnd1(), 1'b0, NO_RES);
      else tick_out();
    end
    if (lk_phase == PH_CKS) begin
      if ($urandom_range(0, 99) < 70) begin
        tick_some(8);
        send_word(CMD_LINE, rnd8(), rnd8(), rnd1(), 1'b0, NO_RES);
      end else begin
        tick_out();
      end
    end
  endtask

  // Both registers are written on back-to-back edges while nothing moves.
  task automatic set_config(input logic [7:0] tmo, input logic [3:0] rty);
    cfg_we    <= 1'b1;
    cfg_index <= REG_TIMEOUT;
    cfg_wdata <= tmo;
    @(posedge clk);
    cfg_index <= REG_RETRY;
    cfg_wdata <= {4'd0, rty};
    @(posedge clk);
    cfg_we      <= 1'b0;
    cfg_timeout = int'(tmo);
    cfg_retry   = int'(rty);
    settings_done++;
  endtask

  // Waits until every predicted word has come out, then a little longer in
  // case the block is still busy with a word that has no result.
  task automatic drain_link();
    s_tvalid <= 1'b0;
    while (link_expect.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic void add_row(input row_kind_t kind, input logic [2:0] cmd,
                                  input logic [7:0] a, input logic [7:0] b, input logic want,
                                  input bit typed, input link_word_t res);
    dir_row_t row;
    row.kind  = kind;
    row.cmd   = cmd;
    row.arg_a = a;
    row.arg_b = b;
    row.want  = want;
    row.typed = typed;
    row.res   = res;
    dir_rows.push_back(row);
  endfunction

  function automatic link_word_t one_result(input logic av, input logic [7:0] ab, input ev_t ev);
    link_word_t w;
    w = NO_RES;
    w.answer_valid = av;
    w.answer_byte  = ab;
    w.ev           = ev;
    w.last         = 1'b1;
    return w;
  endfunction

  //----------------------------------------------------------------------------
  // Main sequence.
  //----------------------------------------------------------------------------
  int phase_tmo [N_PHASES] = '{8, 1, 4, 0, 5};
  int phase_rty [N_PHASES] = '{0, 15, 3, 7, 2};

  initial begin
    int start_items;

    // Under the reset settings: everything that does nothing while idle or
    // loading, then a frame with extreme payload bytes and a full answer.
    add_row(ROW_WORD, CMD_LINE, 8'h00, 8'hFF, 1'b0, 1'b0, NO_RES);
    add_row(ROW_WORD, CMD_TICK, 8'hFF, 8'h00, 1'b1, 1'b0, NO_RES);
    add_row(ROW_WORD, CMD_PAYLOAD, 8'h00, 8'hAA, 1'b0, 1'b0, NO_RES);
    add_row(ROW_WORD, CMD_SEND, 8'hFF, 8'hFF, 1'b1, 1'b0, NO_RES);
    add_row(ROW_WORD, CMD_UNUSED_TOP, 8'hFF, 8'hFF, 1'b1, 1'b0, NO_RES);
    add_row(ROW_WORD, CMD_START, 8'hFF, 8'h00, 1'b1, 1'b0, NO_RES);
    add_row(ROW_WORD, CMD_PAYLOAD, 8'h00, 8'h00, 1'b0, 1'b0, NO_RES);
    add_row(ROW_WORD, CMD_PAYLOAD, 8'h00, 8'hFF, 1'b0, 1'b0, NO_RES);
    add_row(ROW_WORD, CMD_TICK, 8'h00, 8'h00, 1'b0, 1'b0, NO_RES);
    add_row(ROW_WORD, CMD_SEND, 8'h00, 8'h00, 1'b0, 1'b0, NO_RES);
    add_row(ROW_WORD, CMD_LINE, 8'h00, 8'h00, 1'b0, 1'b1, one_result(1'b0, 8'h00, EV_ACKED));
    add_row(ROW_WORD, CMD_LINE, 8'h00, 8'hFF, 1'b0, 1'b1, one_result(1'b1, 8'hFF, EV_NONE));
    add_row(ROW_WORD, CMD_LINE, 8'h00, 8'h00, 1'b0, 1'b1, one_result(1'b1, 8'h00, EV_NONE));
    add_row(ROW_WORD, CMD_LINE, 8'h00, DELIM_LF, 1'b0, 1'b1,
            one_result(1'b0, 8'h00, EV_ANS_DONE));
    add_row(ROW_WORD, CMD_LINE, 8'h00, DELIM_SEMI, 1'b0, 1'b1,
            one_result(1'b0, 8'h00, EV_IDLE));
    // A zero timeout acts as one tick, so every tick times out: one resend,
    // then a failed acknowledge, an answer timeout and a checksum timeout.
    add_row(ROW_CFG, CMD_START, 8'h00, 8'h01, 1'b0, 1'b0, NO_RES);
    add_row(ROW_WORD, CMD_START, 8'h00, 8'h00, 1'b1, 1'b0, NO_RES);
    add_row(ROW_WORD, CMD_SEND, 8'h00, 8'h00, 1'b0, 1'b0, NO_RES);
    add_row(ROW_WORD, CMD_TICK, 8'h00, 8'h00, 1'b0, 1'b0, NO_RES);
    add_row(ROW_WORD, CMD_TICK, 8'h00, 8'h00, 1'b0, 1'b1, one_result(1'b0, 8'h00, EV_ACK_FAIL));
    add_row(ROW_WORD, CMD_TICK, 8'h00, 8'h00, 1'b0, 1'b1, one_result(1'b0, 8'h00, EV_ANS_TMO));
    add_row(ROW_WORD, CMD_START, 8'h81, 8'h00, 1'b1, 1'b0, NO_RES);
    add_row(ROW_WORD, CMD_SEND, 8'h00, 8'h00, 1'b0, 1'b0, NO_RES);
    // A delimiter while waiting for the acknowledge is just an acknowledge.
    add_row(ROW_WORD, CMD_LINE, 8'h00, DELIM_DOLL, 1'b0, 1'b1,
            one_result(1'b0, 8'h00, EV_ACKED));
    add_row(ROW_WORD, CMD_LINE, 8'h00, DELIM_QUERY, 1'b0, 1'b1,
            one_result(1'b0, 8'h00, EV_ANS_DONE));
    add_row(ROW_WORD, CMD_TICK, 8'h00, 8'h00, 1'b0, 1'b1, one_result(1'b0, 8'h00, EV_IDLE));
    // A start while waiting for the acknowledge drops that command.
    add_row(ROW_WORD, CMD_START, 8'h42, 8'h00, 1'b0, 1'b0, NO_RES);
    add_row(ROW_WORD, CMD_PAYLOAD, 8'h00, 8'h7E, 1'b0, 1'b0, NO_RES);
    add_row(ROW_WORD, CMD_SEND, 8'h00, 8'h00, 1'b0, 1'b0, NO_RES);
    add_row(ROW_WORD, CMD_START, 8'h43, 8'h00, 1'b0, 1'b0, NO_RES);
    add_row(ROW_WORD, CMD_LINE, 8'h00, 8'h55, 1'b0, 1'b0, NO_RES);

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        drain_link();
        set_config(dir_rows[i].arg_a, dir_rows[i].arg_b[3:0]);
      end else begin
        send_word(dir_rows[i].cmd, dir_rows[i].arg_a, dir_rows[i].arg_b, dir_rows[i].want,
                  dir_rows[i].typed, dir_rows[i].res);
      end
    end
    drain_link();

    // Random phases, each under its own settings. The second one starts with
    // a full-size frame while the receiver holds off, so the output backs up
    // into the input; the third runs without any idling on either side.
    for (int p = 0; p < N_PHASES; p++) begin
      set_config(8'(phase_tmo[p]), 4'(phase_rty[p]));
      steady = (p == 2);
      start_items = words_sent + ticks_sent;
      if (p == 1) begin
        hold_asks++;
        run_command(1'b1);
      end
      while (words_sent + ticks_sent - start_items < ITEMS_PER_PHASE) begin
        if ($urandom_range(0, 99) < 15) begin
          repeat ($urandom_range(1, 3))
            send_word(3'($urandom_range(0, int'(CMD_UNUSED_TOP))), rnd8(), rnd8(), rnd1(),
                      1'b0, NO_RES);
        end else begin
          run_command(1'b0);
        end
      end
      drain_link();
    end

    $display("run covered %0d command words, %0d ticks and %0d register settings",
             words_sent, ticks_sent, settings_done);
    $display("%0d result words checked, %0d frames incl. resends, %0d cycles of receiver hold",
             words_checked, frames_sent, hold_cycles);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/mdcl_pkg.sv
rtl/mdcl_ram.sv
rtl/multidrop_command_link_master.sv
bench/multidrop_command_link_master_tb.sv
